// ----- sv/nmd_pkg.sv -----
// ----------------------------------------------------------------------------
// Null-delimited message deframer package
// Shared constants, command and status types, and controller states.
// ----------------------------------------------------------------------------
package nmd_pkg;

   localparam int STORE_DEPTH_DEFAULT = 64;
   localparam int BYTE_W              = 8;
   localparam int LEN_W               = 7;

   localparam logic [BYTE_W-1:0] TERMINATOR    = 8'h00;
   localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 7'd64;

   typedef enum logic {
      ST_COLLECT,
      ST_EMIT
   } nmd_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_byte;   // an input item is accepted this cycle
      logic load_data;   // read the next stored byte into the output register
      logic load_term;   // load the terminator into the output register
   } nmd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic starts_msg;  // the offered byte ends a message that is not dropped
      logic more_data;   // stored bytes remain to be given out
      logic out_free;    // the output register can take an item this cycle
   } nmd_status_type;

endpackage

// ----- sv/nmd_ctrl.sv -----
// ----------------------------------------------------------------------------
// Deframer controller
// Two-state machine that alternates between byte intake and message output.
// ----------------------------------------------------------------------------
module nmd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  nmd_pkg::nmd_status_type status,
   output logic                   req_ready,
   output nmd_pkg::nmd_cmd_type    cmd
);
   import nmd_pkg::*;

   nmd_state_type state_ff;
   nmd_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (req_valid && status.starts_msg) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free && !status.more_data) begin
               state_in = ST_COLLECT;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd.take_byte = 1'b0;
      cmd.load_data = 1'b0;
      cmd.load_term = 1'b0;
      unique case (state_ff)
         ST_COLLECT: begin
            req_ready     = 1'b1;
            cmd.take_byte = req_valid;
         end
         ST_EMIT: begin
            cmd.load_data = status.out_free && status.more_data;
            cmd.load_term = status.out_free && !status.more_data;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // No input is taken while a message is being given out.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !cmd.take_byte)
      else $error("byte taken during message output");

   // A terminator load always returns the machine to intake.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_term |=> (state_ff == ST_COLLECT))
      else $error("controller stuck after terminator");

   // Intake of a message end leads straight into output.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.take_byte && status.starts_msg) |=> (state_ff == ST_EMIT))
      else $error("message end did not start output");

endmodule

// ----- sv/nmd_datapath.sv -----
// ----------------------------------------------------------------------------
// Deframer datapath
// Message store, fill count, drop flag, limit register and output register.
// ----------------------------------------------------------------------------
module nmd_datapath #(
   parameter int STORE_DEPTH = nmd_pkg::STORE_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [nmd_pkg::LEN_W-1:0]    csr_wr_data,
   input  logic [nmd_pkg::BYTE_W-1:0]   req_rx_byte,
   input  logic                         rsp_ready,
   input  nmd_pkg::nmd_cmd_type          cmd,
   output nmd_pkg::nmd_status_type       status,
   output logic                         rsp_valid,
   output logic [nmd_pkg::BYTE_W-1:0]   rsp_msg_byte,
   output logic                         rsp_msg_last
);
   import nmd_pkg::*;

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam logic [CW-1:0]    DEPTH_C = CW'(STORE_DEPTH);
   localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(STORE_DEPTH);

   logic [BYTE_W-1:0] store_mem [STORE_DEPTH];

   logic [LEN_W-1:0]  max_len_ff;
   logic [AW-1:0]     fill_ff;
   logic [AW-1:0]     fill_in;
   logic              discard_ff;
   logic              discard_in;
   logic [AW-1:0]     rd_ptr_ff;
   logic [AW-1:0]     rd_ptr_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_last_ff;

   logic [CW-1:0]     limit;
   logic              is_term;
   logic              has_room;
   logic              store_wr;

   // Limit register clamped to the range one to the store depth.
   always_comb begin
      priority if (max_len_ff == '0) begin
         limit = CW'(1);
      end else if (max_len_ff > DEPTH_L) begin
         limit = DEPTH_C;
      end else begin
         limit = CW'(max_len_ff);
      end
   end

   assign is_term  = (req_rx_byte == TERMINATOR);
   assign has_room = ((CW'(fill_ff) + CW'(1)) < limit);
   assign store_wr = cmd.take_byte && !is_term && !discard_ff && has_room;

   assign status.starts_msg = is_term && !discard_ff;
   assign status.more_data  = (rd_ptr_ff < fill_ff);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      fill_in    = fill_ff;
      discard_in = discard_ff;
      rd_ptr_in  = rd_ptr_ff;
      if (cmd.take_byte) begin
         priority if (is_term) begin
            // A dropped message ends here; a good one is now given out.
            if (discard_ff) begin
               discard_in = 1'b0;
               fill_in    = '0;
            end
         end else if (!discard_ff) begin
            if (has_room) begin
               fill_in = fill_ff + AW'(1);
            end else begin
               discard_in = 1'b1;
               fill_in    = '0;
            end
         end
      end
      if (cmd.load_data) begin
         rd_ptr_in = rd_ptr_ff + AW'(1);
      end
      if (cmd.load_term) begin
         rd_ptr_in = '0;
         fill_in   = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_data || cmd.load_term) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= MAX_LEN_RESET;
         fill_ff      <= '0;
         discard_ff   <= 1'b0;
         rd_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         fill_ff      <= fill_in;
         discard_ff   <= discard_in;
         rd_ptr_ff    <= rd_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Store write port.
   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_mem[fill_ff] <= req_rx_byte;
      end
   end

   // Store read port; the output register doubles as the read data register.
   always_ff @(posedge clock) begin
      if (cmd.load_data) begin
         rsp_byte_ff <= store_mem[rd_ptr_ff];
         rsp_last_ff <= 1'b0;
      end else if (cmd.load_term) begin
         rsp_byte_ff <= TERMINATOR;
         rsp_last_ff <= 1'b1;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_msg_byte = rsp_byte_ff;
   assign rsp_msg_last = rsp_last_ff;

   // A pending item is never overwritten.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.load_data || cmd.load_term) |-> status.out_free)
      else $error("output register overwritten");

   // While a message is being dropped nothing is counted.
   assert property (@(posedge clock) disable iff (reset)
      discard_ff |-> (fill_ff == '0))
      else $error("fill count nonzero while dropping");

   // The terminator closes the message and clears the count.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_term |=> (rsp_last_ff && fill_ff == '0 && rd_ptr_ff == '0))
      else $error("terminator did not close the message");

   // A stored byte advances the count by one.
   assert property (@(posedge clock) disable iff (reset)
      store_wr |=> (fill_ff == $past(fill_ff) + AW'(1)))
      else $error("fill count did not advance");

endmodule

// ----- sv/null_delimited_message_deframer.sv -----
// ----------------------------------------------------------------------------
// Null-delimited message deframer
// Splits a byte stream into zero-terminated messages and gives them out.
// ----------------------------------------------------------------------------
// Bytes enter on the req_ channel, one item per byte, and are collected in a
// message store of STORE_DEPTH entries. While collecting, the block takes one
// byte per clock cycle. A zero byte ends the message: if the message, its
// terminator included, fits within the limit in csr_wr_data (values of zero
// act as one, values above STORE_DEPTH act as STORE_DEPTH), its bytes come
// out on the rsp_ channel in order, followed by the zero terminator with
// rsp_msg_last set. A message that outgrows the limit is dropped entirely:
// every byte through its terminator is swallowed without any result. During
// output the input is held off; a message of n stored bytes gives n + 1
// output items, one store read per cycle through the store's single read
// port whenever rsp_ready leaves the output register free. The next message's
// first byte is taken in the cycle after the terminator is loaded, while the
// terminator may still wait in the output register. The limit register
// resets to 64 and should be written only while the block is idle.
// ----------------------------------------------------------------------------
module null_delimited_message_deframer #(
   parameter int STORE_DEPTH = nmd_pkg::STORE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [nmd_pkg::LEN_W-1:0]   csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [nmd_pkg::BYTE_W-1:0]  req_rx_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [nmd_pkg::BYTE_W-1:0]  rsp_msg_byte,
   output logic                        rsp_msg_last
);
   import nmd_pkg::*;

   nmd_cmd_type    cmd;
   nmd_status_type status;

   // The controller sequences intake and output.
   nmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   // The datapath holds the store, the counters and the output register.
   nmd_datapath #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_rx_byte  (req_rx_byte),
      .rsp_ready    (rsp_ready),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_msg_byte (rsp_msg_byte),
      .rsp_msg_last (rsp_msg_last)
   );

endmodule
